@@ rtl/core/plt_pkg.sv @@
// ----------------------------------------------------------------------------
// plt_pkg: shared types and tables for the piecewise-linear tanh core
// Segment bounds, slopes and biases, datapath widths and the stage control word.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int X_W        = 32;
  localparam int MAG_W      = 31;
  localparam int Y_W        = 60;
  localparam int SLOPE_W    = 32;
  localparam int BIAS_W     = 28;
  localparam int BOUND_W    = 32;
  localparam int BIAS_SHIFT = 30;

  localparam int TABLE_SEGMENTS    = 16;
  localparam int SEG_IDX_W         = 4;
  localparam int SEGMENT_COUNT_DEF = 16;

  // last bound is 2^31, above every magnitude
  localparam logic [BOUND_W-1:0] SEG_UPPER [TABLE_SEGMENTS] = '{
    32'd33584191,  32'd58182438,  32'd80361293,  32'd102120620,
    32'd124483371, 32'd148392654, 32'd174972063, 32'd206183541,
    32'd244722657, 32'd281591256, 32'd312045360, 32'd358241226,
    32'd403095772, 32'd471425623, 32'd530372454, 32'd2147483648
  };

  localparam logic [SLOPE_W-1:0] SEG_SLOPE [TABLE_SEGMENTS] = '{
    32'd2114623134, 32'd1910645334, 32'd1662969581, 32'd1396521636,
    32'd1131979061, 32'd881027392,  32'd652221876,  32'd451080022,
    32'd281798391,  32'd159724746,  32'd98692663,   32'd60001039,
    32'd27632752,   32'd13732196,   32'd2832019,    32'd172634
  };

  localparam logic [BIAS_W-1:0] SEG_BIAS [TABLE_SEGMENTS] = '{
    28'd0,         28'd6379959,   28'd19800670,  28'd39742244,
    28'd64902158,  28'd93996032,  28'd125617281, 28'd158394439,
    28'd190900471, 28'd218722976, 28'd234728779, 28'd245973141,
    28'd256772436, 28'd261990874, 28'd266776590, 28'd268090187
  };

  typedef struct packed {
    logic vld;
    logic neg;
  } ctl_t;

endpackage

@@ rtl/core/plt_seg_select.sv @@
// ----------------------------------------------------------------------------
// plt_seg_select: magnitude and segment lookup stages
// Stage 1 takes sign and magnitude, stage 2 compares against the bounds and
// registers the chosen slope and bias.
// ----------------------------------------------------------------------------
module plt_seg_select #(
  parameter int SEGMENT_COUNT = plt_pkg::SEGMENT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic signed [plt_pkg::X_W-1:0]  in_x,
  output plt_pkg::ctl_t                   ctl_o,
  output logic [plt_pkg::MAG_W-1:0]       mag_o,
  output logic [plt_pkg::SLOPE_W-1:0]     slope_o,
  output logic [plt_pkg::BIAS_W-1:0]      bias_o
);

  localparam int USED = (SEGMENT_COUNT > plt_pkg::TABLE_SEGMENTS) ?
                        plt_pkg::TABLE_SEGMENTS : SEGMENT_COUNT;

  plt_pkg::ctl_t                 ctl1_r, ctl1_nxt;
  plt_pkg::ctl_t                 ctl2_r;
  logic [plt_pkg::MAG_W-1:0]     mag1_r, mag1_nxt;
  logic [plt_pkg::MAG_W-1:0]     mag2_r;
  logic [plt_pkg::SLOPE_W-1:0]   slope2_r, slope2_nxt;
  logic [plt_pkg::BIAS_W-1:0]    bias2_r, bias2_nxt;
  logic [plt_pkg::X_W-1:0]       neg_x;
  logic [plt_pkg::SEG_IDX_W-1:0] seg;
  logic [USED-2:0]               le;

  // stage 1: sign and magnitude, most negative word saturates
  always_comb begin
    neg_x        = plt_pkg::X_W'(-in_x);
    ctl1_nxt.vld = in_vld;
    ctl1_nxt.neg = in_x[plt_pkg::X_W-1];
    if (!in_x[plt_pkg::X_W-1]) begin
      mag1_nxt = in_x[plt_pkg::MAG_W-1:0];
    end else if (in_x[plt_pkg::MAG_W-1:0] == '0) begin
      mag1_nxt = '1;
    end else begin
      mag1_nxt = neg_x[plt_pkg::MAG_W-1:0];
    end
  end

  // stage 2: first bound not exceeded, last used segment catches the rest
  always_comb begin
    for (int k = 0; k < USED - 1; k++) begin
      le[k] = {1'b0, mag1_r} <= plt_pkg::SEG_UPPER[k];
    end
    seg = plt_pkg::SEG_IDX_W'(USED - 1);
    for (int k = USED - 2; k >= 0; k--) begin
      if (le[k]) seg = plt_pkg::SEG_IDX_W'(k);
    end
    slope2_nxt = plt_pkg::SEG_SLOPE[seg];
    bias2_nxt  = plt_pkg::SEG_BIAS[seg];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r   <= mag1_nxt;
    mag2_r   <= mag1_r;
    slope2_r <= slope2_nxt;
    bias2_r  <= bias2_nxt;
  end

  assign ctl_o   = ctl2_r;
  assign mag_o   = mag2_r;
  assign slope_o = slope2_r;
  assign bias_o  = bias2_r;

endmodule

@@ rtl/core/plt_mac.sv @@
// ----------------------------------------------------------------------------
// plt_mac: multiply, bias add and sign stages
// Stage 3 multiplies, stage 4 adds the shifted bias, stage 5 applies the sign.
// ----------------------------------------------------------------------------
module plt_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plt_pkg::ctl_t                     ctl_i,
  input  logic [plt_pkg::MAG_W-1:0]         mag_i,
  input  logic [plt_pkg::SLOPE_W-1:0]       slope_i,
  input  logic [plt_pkg::BIAS_W-1:0]        bias_i,
  output logic                              out_valid,
  output logic signed [plt_pkg::Y_W-1:0]    out_y
);

  localparam int PROD_W = plt_pkg::MAG_W + plt_pkg::SLOPE_W;

  plt_pkg::ctl_t               ctl3_r, ctl4_r, ctl5_r;
  logic [PROD_W-1:0]           prod;
  logic [plt_pkg::Y_W-1:0]     prod3_r, prod3_nxt;
  logic [plt_pkg::BIAS_W-1:0]  bias3_r;
  logic [plt_pkg::Y_W-1:0]     sum4_r, sum4_nxt;
  logic [plt_pkg::Y_W-1:0]     y5_r, y5_nxt;

  // everything is kept modulo 2^60, matching the output mask
  always_comb begin
    prod      = PROD_W'(mag_i) * PROD_W'(slope_i);
    prod3_nxt = prod[plt_pkg::Y_W-1:0];
    sum4_nxt  = prod3_r + (plt_pkg::Y_W'(bias3_r) << plt_pkg::BIAS_SHIFT);
    y5_nxt    = ctl4_r.neg ? plt_pkg::Y_W'(-sum4_r) : sum4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl3_r <= ctl_i;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    prod3_r <= prod3_nxt;
    bias3_r <= bias_i;
    sum4_r  <= sum4_nxt;
    y5_r    <= y5_nxt;
  end

  assign out_valid = ctl5_r.vld;
  assign out_y     = y5_r;

endmodule

@@ rtl/core/piecewise_linear_tanh_core.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_tanh_core: 16-segment piecewise-linear tanh
// Signed 32-bit sample in, signed 60-bit fixed-point tanh approximation out.
// ----------------------------------------------------------------------------
// usage:
//   a word is taken at each rising edge where start is high and busy is low;
//   busy stays low, so a new sample may be presented every cycle
//   each sample gives one result word on out_y, marked by out_valid for
//   exactly one cycle, after the sign stage has registered it
//   throughput is one word per cycle, set by the five-stage pipeline:
//   magnitude, bound compare and table lookup, multiply, bias add, sign
//   results leave in the order samples came in
//   synchronous reset clears the stage valid bits; words in flight are dropped
//   the receiver cannot stall, so there is no back pressure path
//   SEGMENT_COUNT selects how many table segments are used (clamped to 16);
//   the last one in use takes every larger magnitude
// ----------------------------------------------------------------------------
module piecewise_linear_tanh_core #(
  parameter int SEGMENT_COUNT = plt_pkg::SEGMENT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [plt_pkg::X_W-1:0]  in_x,
  output logic                            out_valid,
  output logic signed [plt_pkg::Y_W-1:0]  out_y
);

  plt_pkg::ctl_t               sel_ctl;
  logic [plt_pkg::MAG_W-1:0]   sel_mag;
  logic [plt_pkg::SLOPE_W-1:0] sel_slope;
  logic [plt_pkg::BIAS_W-1:0]  sel_bias;

  assign busy = 1'b0;

  plt_seg_select #(
    .SEGMENT_COUNT (SEGMENT_COUNT)
  ) u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start & ~busy),
    .in_x    (in_x),
    .ctl_o   (sel_ctl),
    .mag_o   (sel_mag),
    .slope_o (sel_slope),
    .bias_o  (sel_bias)
  );

  plt_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (sel_ctl),
    .mag_i     (sel_mag),
    .slope_i   (sel_slope),
    .bias_i    (sel_bias),
    .out_valid (out_valid),
    .out_y     (out_y)
  );

endmodule
